// File: sv/sorted_priority_queue_dedup_core_defines.svh
// assertion macros for the sorted priority queue core
`ifndef SORTED_PRIORITY_QUEUE_DEDUP_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEDUP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// antecedent implies consequent in the next cycle
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`else

`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/spq_pkg.sv
// shared types and constants of the sorted priority queue core
package spq_pkg;

    localparam int KEY_W     = 64;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 5;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_DUPLICATE = 3'd1;
    localparam t_status ST_REMOVED   = 3'd2;
    localparam t_status ST_EMPTY     = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rem_en;
    } t_cell_ctl;

endpackage

// File: sv/spq_cell.sv
// one cell of the sorted chain: a key, a payload and compare flags
module spq_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                            i_clk,
    input  spq_pkg::t_cell_ctl              i_ctl,
    input  logic                            i_occ,
    input  logic [KEY_BITS-1:0]             i_key,
    input  logic [spq_pkg::PAYLOAD_W-1:0]   i_payload,
    input  logic                            i_prev_lt,
    input  logic [KEY_BITS-1:0]             i_prev_key,
    input  logic [spq_pkg::PAYLOAD_W-1:0]   i_prev_payload,
    input  logic [KEY_BITS-1:0]             i_next_key,
    input  logic [spq_pkg::PAYLOAD_W-1:0]   i_next_payload,
    output logic [KEY_BITS-1:0]             o_key,
    output logic [spq_pkg::PAYLOAD_W-1:0]   o_payload,
    output logic                            o_lt,
    output logic                            o_eq
);

    logic [KEY_BITS-1:0]           r_key;
    logic [KEY_BITS-1:0]           n_key;
    logic [spq_pkg::PAYLOAD_W-1:0] r_payload;
    logic [spq_pkg::PAYLOAD_W-1:0] n_payload;
    logic                          r_lt;
    logic                          r_eq;

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        if (i_ctl.ins_en) begin
            // smaller keys stay, the insertion point loads, the rest shift up
            if (!r_lt) begin
                if (i_prev_lt) begin
                    n_key     = i_key;
                    n_payload = i_payload;
                end else begin
                    n_key     = i_prev_key;
                    n_payload = i_prev_payload;
                end
            end
        end else if (i_ctl.rem_en) begin
            n_key     = i_next_key;
            n_payload = i_next_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
        if (i_ctl.cmp_en) begin
            r_lt <= i_occ && (r_key < i_key);
            r_eq <= i_occ && (r_key == i_key);
        end
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_lt      = r_lt;
    assign o_eq      = r_eq;

endmodule

// File: sv/sorted_priority_queue_dedup_core.sv
// top level of the sorted priority queue with duplicate rejection
//
//  channel  direction  handshake                   fields
//  in       to core    i_in_valid / o_in_stall      i_kind, i_key, i_payload
//  out      from core  o_out_valid / i_out_stall    o_status, o_out_key, o_out_payload,
//                                                   o_occupancy, o_is_empty
//
// each request passes through a compare state, in which every cell compares its key
// with the request key, then an apply state, in which the chain shifts and the result
// is registered; a new request is taken in the apply state, as that result is registered
// the result register frees the input side; a stalled result holds the chain in its
// apply state until the result slot is free
// reset clears the fill count and the control; cell contents need no reset
`include "sorted_priority_queue_dedup_core_defines.svh"

module sorted_priority_queue_dedup_core #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [spq_pkg::KEY_W-1:0]       i_key,
    input  logic [spq_pkg::PAYLOAD_W-1:0]   i_payload,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [spq_pkg::STATUS_W-1:0]    o_status,
    output logic [spq_pkg::KEY_W-1:0]       o_out_key,
    output logic [spq_pkg::PAYLOAD_W-1:0]   o_out_payload,
    output logic [spq_pkg::OCC_W-1:0]       o_occupancy,
    output logic                            o_is_empty
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    t_state                          r_state;
    t_state                          n_state;

    // captured request
    logic                            r_kind;
    logic [KEY_BITS-1:0]             r_key;
    logic [spq_pkg::PAYLOAD_W-1:0]   r_payload;

    // fill count, entries 0 .. count-1 of the chain hold keys in ascending order
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;

    // result register
    logic                            r_out_valid;
    spq_pkg::t_status                r_status;
    spq_pkg::t_status                n_status;
    logic [spq_pkg::KEY_W-1:0]       r_out_key;
    logic [spq_pkg::KEY_W-1:0]       n_out_key;
    logic [spq_pkg::PAYLOAD_W-1:0]   r_out_payload;
    logic [spq_pkg::PAYLOAD_W-1:0]   n_out_payload;
    logic [spq_pkg::OCC_W-1:0]       r_occ;
    logic                            r_is_empty;

    spq_pkg::t_cell_ctl              cell_ctl;
    logic [KEY_BITS-1:0]             cell_key     [DEPTH];
    logic [spq_pkg::PAYLOAD_W-1:0]   cell_payload [DEPTH];
    logic [DEPTH-1:0]                lt_vec;
    logic [DEPTH-1:0]                eq_vec;
    logic [DEPTH-1:0]                occ_vec;

    logic                            in_accept;
    logic                            out_free;
    logic                            apply_go;
    logic                            is_dup;
    logic                            is_full;
    logic                            is_none;
    logic [KEY_BITS+spq_pkg::KEY_W-1:0]  head_key_ext;
    logic [CW+spq_pkg::OCC_W-1:0]        count_ext;

    // ---------------------------------------------------------------
    // chain of cells
    // ---------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                          prev_lt;
        logic [KEY_BITS-1:0]           prev_key;
        logic [spq_pkg::PAYLOAD_W-1:0] prev_payload;
        logic [KEY_BITS-1:0]           next_key;
        logic [spq_pkg::PAYLOAD_W-1:0] next_payload;

        // the head cell sees a virtual smaller neighbor so it loads when not below
        if (g == 0) begin : g_head
            assign prev_lt      = 1'b1;
            assign prev_key     = '0;
            assign prev_payload = '0;
        end else begin : g_body
            assign prev_lt      = lt_vec[g-1];
            assign prev_key     = cell_key[g-1];
            assign prev_payload = cell_payload[g-1];
        end

        // the last cell keeps its own content on a remove
        if (g == DEPTH - 1) begin : g_last
            assign next_key     = cell_key[g];
            assign next_payload = cell_payload[g];
        end else begin : g_inner
            assign next_key     = cell_key[g+1];
            assign next_payload = cell_payload[g+1];
        end

        assign occ_vec[g] = (CW'(g) < r_count);

        spq_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (cell_ctl),
            .i_occ          (occ_vec[g]),
            .i_key          (r_key),
            .i_payload      (r_payload),
            .i_prev_lt      (prev_lt),
            .i_prev_key     (prev_key),
            .i_prev_payload (prev_payload),
            .i_next_key     (next_key),
            .i_next_payload (next_payload),
            .o_key          (cell_key[g]),
            .o_payload      (cell_payload[g]),
            .o_lt           (lt_vec[g]),
            .o_eq           (eq_vec[g])
        );
    end

    // ---------------------------------------------------------------
    // request decode
    // ---------------------------------------------------------------
    assign out_free   = !r_out_valid || !i_out_stall;
    assign apply_go   = (r_state == S_APPLY) && out_free;
    // no request is taken while reset is held
    assign o_in_stall = !i_rst_n || !((r_state == S_IDLE) || apply_go);
    assign in_accept  = i_in_valid && !o_in_stall;

    // the compare flags are registered, so the match search is a plain or-tree
    assign is_dup  = |eq_vec;
    assign is_full = (r_count == CW'(DEPTH));
    assign is_none = (r_count == '0);

    assign head_key_ext = {{spq_pkg::KEY_W{1'b0}}, cell_key[0]};
    assign count_ext    = {{spq_pkg::OCC_W{1'b0}}, n_count};

    always_comb begin
        cell_ctl        = '0;
        cell_ctl.cmp_en = (r_state == S_CMP);
        n_count         = r_count;
        n_status        = spq_pkg::ST_INSERTED;
        n_out_key       = '0;
        n_out_payload   = '0;
        if (r_kind == spq_pkg::KIND_INSERT) begin
            // a duplicate wins over a full store
            if (is_dup) begin
                n_status = spq_pkg::ST_DUPLICATE;
            end else if (is_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_status        = spq_pkg::ST_INSERTED;
                cell_ctl.ins_en = apply_go;
                n_count         = r_count + 1'b1;
            end
        end else begin
            if (is_none) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_status        = spq_pkg::ST_REMOVED;
                n_out_key       = head_key_ext[spq_pkg::KEY_W-1:0];
                n_out_payload   = cell_payload[0];
                cell_ctl.rem_en = apply_go;
                n_count         = r_count - 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_accept) n_state = S_CMP;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: begin
                if (apply_go) begin
                    n_state = in_accept ? S_CMP : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // state, count and result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (apply_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_accept) begin
            r_kind    <= i_kind;
            r_key     <= i_key[KEY_BITS-1:0];
            r_payload <= i_payload;
        end
        if (apply_go) begin
            r_status      <= n_status;
            r_out_key     <= n_out_key;
            r_out_payload <= n_out_payload;
            r_occ         <= count_ext[spq_pkg::OCC_W-1:0];
            r_is_empty    <= (n_count == '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_key     = r_out_key;
    assign o_out_payload = r_out_payload;
    assign o_occupancy   = r_occ;
    assign o_is_empty    = r_is_empty;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // the fill count never passes the chain length
    `SPQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    // sorted distinct keys give at most one equal cell
    `SPQ_ASSERT_IMP(a_eq_single, i_clk, i_rst_n, r_state == S_APPLY, $onehot0(eq_vec))
    // a remove from a non-empty chain takes exactly one entry
    `SPQ_ASSERT_NXT(a_remove_dec, i_clk, i_rst_n,
        apply_go && (r_kind == spq_pkg::KIND_REMOVE) && !is_none,
        r_count == $past(r_count) - 1'b1)
    // a rejected duplicate leaves the count alone
    `SPQ_ASSERT_NXT(a_dup_keep, i_clk, i_rst_n,
        apply_go && (r_kind == spq_pkg::KIND_INSERT) && is_dup,
        $stable(r_count))

endmodule

// File: tb/tb_sorted_priority_queue_dedup_core.sv
// self-checking testbench of the sorted priority queue core with duplicate rejection
module tb_sorted_priority_queue_dedup_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 8;
    localparam int DEPTH         = 16;
    localparam int KEY_BITS      = 64;
    localparam int RANDOM_ITEMS  = 400;
    localparam int PHASE_LEN     = 40;
    localparam int KEY_POOL_SIZE = 12;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;

    // only the low KEY_BITS of a key take part in ordering and matching
    localparam logic [spq_pkg::KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= spq_pkg::KEY_W) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);

    // one result as the core reports it
    typedef struct packed {
        spq_pkg::t_status                status;
        logic [spq_pkg::KEY_W-1:0]       out_key;
        logic [spq_pkg::PAYLOAD_W-1:0]   out_payload;
        logic [spq_pkg::OCC_W-1:0]       occupancy;
        logic                            is_empty;
    } t_queue_result;

    // one row of directed stimulus, repeated reps times with a stepping key
    typedef struct {
        logic                            kind;
        logic [spq_pkg::KEY_W-1:0]       key;
        logic [spq_pkg::KEY_W-1:0]       key_step;
        logic [spq_pkg::PAYLOAD_W-1:0]   payload;
        int                              reps;
        logic                            typed;
        t_queue_result                   result;
    } t_stim_row;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_in_valid    = 1'b0;
    logic                            i_kind        = spq_pkg::KIND_INSERT;
    logic [spq_pkg::KEY_W-1:0]       i_key         = '0;
    logic [spq_pkg::PAYLOAD_W-1:0]   i_payload     = '0;
    logic                            i_out_stall   = 1'b0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic [spq_pkg::STATUS_W-1:0]    o_status;
    logic [spq_pkg::KEY_W-1:0]       o_out_key;
    logic [spq_pkg::PAYLOAD_W-1:0]   o_out_payload;
    logic [spq_pkg::OCC_W-1:0]       o_occupancy;
    logic                            o_is_empty;

    sorted_priority_queue_dedup_core #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow copy of the sorted store, ascending by key
    logic [spq_pkg::KEY_W-1:0]       held_keys [DEPTH];
    logic [spq_pkg::PAYLOAD_W-1:0]   held_payloads [DEPTH];
    int                              held_count = 0;

    // results still owed by the core, oldest first
    t_queue_result                   pending_results [$];

    logic [spq_pkg::KEY_W-1:0]       key_pool [KEY_POOL_SIZE];
    logic                            quiet = 1'b0;
    int                              error_count = 0;
    int                              idle_cycles = 0;

    // directed rows: empty remove, both key extremes, duplicate, fill to
    // full, full rejection and duplicate while full
    t_stim_row directed_rows [10] = '{
        // remove from empty gives zero key and payload
        '{spq_pkg::KIND_REMOVE, 64'd0, 64'd0, 32'd0, 1, 1'b1,
          '{spq_pkg::ST_EMPTY, 64'd0, 32'd0, 5'd0, 1'b1}},
        // smallest and largest keys
        '{spq_pkg::KIND_INSERT, 64'd0, 64'd0, 32'd0, 1, 1'b1,
          '{spq_pkg::ST_INSERTED, 64'd0, 32'd0, 5'd1, 1'b0}},
        '{spq_pkg::KIND_INSERT, '1, 64'd0, '1, 1, 1'b1,
          '{spq_pkg::ST_INSERTED, 64'd0, 32'd0, 5'd2, 1'b0}},
        // equal key is turned away, store unchanged
        '{spq_pkg::KIND_INSERT, 64'd0, 64'd0, 32'h0000_0005, 1, 1'b1,
          '{spq_pkg::ST_DUPLICATE, 64'd0, 32'd0, 5'd2, 1'b0}},
        '{spq_pkg::KIND_REMOVE, '1, 64'd0, '1, 1, 1'b1,
          '{spq_pkg::ST_REMOVED, 64'd0, 32'd0, 5'd1, 1'b0}},
        '{spq_pkg::KIND_REMOVE, 64'd0, 64'd0, 32'd0, 1, 1'b1,
          '{spq_pkg::ST_REMOVED, '1, '1, 5'd0, 1'b1}},
        // fill with descending keys so every insert lands at the head
        '{spq_pkg::KIND_INSERT, '1, 64'hEEEE_EEEE_EEEE_EEEF, 32'hA5A5_5A50, DEPTH, 1'b0,
          '{spq_pkg::ST_INSERTED, 64'd0, 32'd0, 5'd0, 1'b0}},
        // new key into a full store
        '{spq_pkg::KIND_INSERT, 64'h0123_4567_89AB_CDEF, 64'd0, 32'h1234_5678, 1, 1'b1,
          '{spq_pkg::ST_FULL, 64'd0, 32'd0, 5'd16, 1'b0}},
        // duplicate check wins over the full check
        '{spq_pkg::KIND_INSERT, 64'h7777_7777_7777_7777, 64'd0, 32'h8765_4321, 1, 1'b1,
          '{spq_pkg::ST_DUPLICATE, 64'd0, 32'd0, 5'd16, 1'b0}},
        '{spq_pkg::KIND_REMOVE, 64'd0, 64'd0, 32'd0, 1, 1'b1,
          '{spq_pkg::ST_REMOVED, 64'd0, 32'hA5A5_5A5F, 5'd15, 1'b0}}
    };

    // applies one request to the shadow store and returns the result it owes
    function automatic t_queue_result queue_op(input logic kind,
                                               input logic [spq_pkg::KEY_W-1:0] key,
                                               input logic [spq_pkg::PAYLOAD_W-1:0] payload);
        t_queue_result             res;
        logic [spq_pkg::KEY_W-1:0] k;
        int                        pos;
        res = '0;
        k   = key & KEY_MASK;
        pos = 0;
        if (kind == spq_pkg::KIND_INSERT) begin
            while (pos < held_count && held_keys[pos] < k) pos++;
            if (pos < held_count && held_keys[pos] == k) begin
                res.status = spq_pkg::ST_DUPLICATE;
            end else if (held_count >= DEPTH) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                for (int i = held_count; i > pos; i--) begin
                    held_keys[i]     = held_keys[i-1];
                    held_payloads[i] = held_payloads[i-1];
                end
                held_keys[pos]     = k;
                held_payloads[pos] = payload;
                held_count++;
                res.status = spq_pkg::ST_INSERTED;
            end
        end else if (held_count == 0) begin
            res.status = spq_pkg::ST_EMPTY;
        end else begin
            res.status      = spq_pkg::ST_REMOVED;
            res.out_key     = held_keys[0];
            res.out_payload = held_payloads[0];
            for (int i = 1; i < held_count; i++) begin
                held_keys[i-1]     = held_keys[i];
                held_payloads[i-1] = held_payloads[i];
            end
            held_count--;
        end
        res.occupancy = spq_pkg::OCC_W'(held_count);
        res.is_empty  = (held_count == 0);
        return res;
    endfunction

    // offers one request after a random gap and holds it until taken;
    // a typed row supplies its own expected result, the rest use the shadow store
    task automatic send_request(input logic kind, input logic [spq_pkg::KEY_W-1:0] key,
                                input logic [spq_pkg::PAYLOAD_W-1:0] payload,
                                input logic typed, input t_queue_result typed_result);
        int            gap;
        t_queue_result res;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        i_payload  <= payload;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        res = queue_op(kind, key, payload);
        pending_results.push_back(typed ? typed_result : res);
    endtask

    // request side: directed table, then random phases
    initial begin
        int                        insert_pct;
        int                        sel;
        logic                      kind;
        logic [spq_pkg::KEY_W-1:0] key;
        for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int n = 0; n < directed_rows[r].reps; n++) begin
                send_request(directed_rows[r].kind,
                             directed_rows[r].key
                                 + spq_pkg::KEY_W'(n) * directed_rows[r].key_step,
                             directed_rows[r].payload + spq_pkg::PAYLOAD_W'(n),
                             directed_rows[r].typed, directed_rows[r].result);
            end
        end

        // phases lean toward draining, filling or churning the store; every
        // fourth phase runs without gaps on either side
        insert_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                case ((n / PHASE_LEN) % 3)
                    0: begin
                        insert_pct = 15;
                    end
                    1: begin
                        insert_pct = 85;
                    end
                    default: begin
                        insert_pct = 50;
                    end
                endcase
                quiet = ((n / PHASE_LEN) % 4 == 3);
            end
            kind = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::KIND_INSERT
                                                        : spq_pkg::KIND_REMOVE;
            // pooled keys come back often enough to hit duplicates
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                key = '0;
            end else if (sel == 1) begin
                key = '1;
            end else if (sel <= 5) begin
                key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            end else begin
                key = {$urandom, $urandom};
            end
            send_request(kind, key, $urandom, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("sorted_priority_queue_dedup_core test passed");
        end else begin
            $display("sorted_priority_queue_dedup_core test failed");
        end
        $finish;
    end

    // result side: random stall before each result, then compare with the oldest expectation
    initial begin
        int            gap;
        t_queue_result want;
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall && i_rst_n));
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d", o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_out_key !== want.out_key) begin
                    $error("out_key: expected %h, got %h", want.out_key, o_out_key);
                    error_count++;
                end
                if (o_out_payload !== want.out_payload) begin
                    $error("out_payload: expected %h, got %h", want.out_payload,
                           o_out_payload);
                    error_count++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, o_occupancy);
                    error_count++;
                end
                if (o_is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, o_is_empty);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long with no request or result taken means the core hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("sorted_priority_queue_dedup_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
